>>> sv/polar_gaussian_transform_unit_defines.svh
// assertion macros for the polar gaussian transform unit
`ifndef POLAR_GAUSSIAN_TRANSFORM_UNIT_DEFINES_SVH
`define POLAR_GAUSSIAN_TRANSFORM_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PGT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgt assertion failed");
`define PGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgt assertion failed");
`else
`define PGT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/pgt_pkg.sv
// shared constants, types and functions of the polar gaussian transform unit
package pgt_pkg;

    localparam int UNIFORM_BITS  = 32;
    localparam int OUT_FRAC_BITS = 27;

    localparam int U_SHR = (UNIFORM_BITS >= 31) ? UNIFORM_BITS - 31 : 0;
    localparam int U_SHL = (UNIFORM_BITS < 31) ? 31 - UNIFORM_BITS : 0;
    localparam int O_SHL = (OUT_FRAC_BITS >= 28) ? OUT_FRAC_BITS - 28 : 0;
    localparam int O_SHR = (OUT_FRAC_BITS < 28) ? 28 - OUT_FRAC_BITS : 1;

    localparam int T_W        = 61;
    localparam int E_W        = 6;
    localparam int D_W        = 33;
    localparam int Q_W        = 32;
    localparam int NORM_STEPS = 6;
    localparam int LOG_ITERS  = 30;
    localparam int SQRT_BITS  = 32;

    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic [T_W-1:0] pa;
        logic [T_W-1:0] pb;
        logic [E_W-1:0] e;
        logic           na;
        logic           nb;
    } t_norm_data;

    function automatic logic [30:0] to_q31(input logic [31:0] raw);
        logic [63:0] u;
        u = {32'b0, raw} & ((64'd1 << UNIFORM_BITS) - 64'd1);
        u = (u >> U_SHR) << U_SHL;
        return u[30:0];
    endfunction

endpackage

>>> sv/pgt_norm.sv
// normalizing shifter: scales s and both squares until s reaches one
module pgt_norm import pgt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_norm_data i_data,
    output logic       o_valid,
    output t_norm_data o_data
);

    t_norm_data r_data  [1:NORM_STEPS];
    logic       r_valid [1:NORM_STEPS];

    for (genvar i = 0; i < NORM_STEPS; i++) begin : g_stage
        localparam int K = 1 << (NORM_STEPS - 1 - i);
        t_norm_data w_cur;
        t_norm_data n_data;
        logic       w_v;

        if (i == 0) begin : g_first
            assign w_cur = i_data;
            assign w_v   = i_valid;
        end else begin : g_next
            assign w_cur = r_data[i];
            assign w_v   = r_valid[i];
        end

        always_comb begin
            n_data = w_cur;
            if (w_cur.t[T_W-1 -: K] == '0) begin
                n_data.t  = w_cur.t << K;
                n_data.pa = w_cur.pa << K;
                n_data.pb = w_cur.pb << K;
                n_data.e  = w_cur.e + E_W'(K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_data[i+1] <= n_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= w_v;
            end
        end
    end

    assign o_valid = r_valid[NORM_STEPS];
    assign o_data  = r_data[NORM_STEPS];

endmodule

>>> sv/pgt_log.sv
// log pipeline: squaring log2 of the mantissa, then -ln(s) in q.26
module pgt_log import pgt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [T_W-1:0] i_t,
    input  logic [E_W-1:0] i_e,
    output logic           o_valid,
    output logic [31:0]    o_l26
);

    logic [30:0]          r_f  [1:LOG_ITERS];
    logic [LOG_ITERS-1:0] r_fr [1:LOG_ITERS];
    logic [E_W-1:0]       r_e  [1:LOG_ITERS];
    logic                 r_v  [1:LOG_ITERS];

    for (genvar i = 0; i < LOG_ITERS; i++) begin : g_iter
        logic [30:0]          w_f;
        logic [LOG_ITERS-1:0] w_fr;
        logic [E_W-1:0]       w_e;
        logic                 w_v;
        logic [61:0]          w_prod;
        logic [30:0]          n_f;
        logic [LOG_ITERS-1:0] n_fr;

        if (i == 0) begin : g_first
            assign w_f  = i_t[T_W-1:30];
            assign w_fr = '0;
            assign w_e  = i_e;
            assign w_v  = i_valid;
        end else begin : g_next
            assign w_f  = r_f[i];
            assign w_fr = r_fr[i];
            assign w_e  = r_e[i];
            assign w_v  = r_v[i];
        end

        always_comb begin
            w_prod = {31'b0, w_f} * {31'b0, w_f};
            if (w_prod[61]) begin
                n_f  = w_prod[61:31];
                n_fr = {w_fr[LOG_ITERS-2:0], 1'b1};
            end else begin
                n_f  = w_prod[60:30];
                n_fr = {w_fr[LOG_ITERS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[i+1]  <= n_f;
                r_fr[i+1] <= n_fr;
                r_e[i+1]  <= w_e;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= w_v;
            end
        end
    end

    logic [35:0] r_n;
    logic        r_v_n;
    logic [31:0] r_l26;
    logic        r_v_l;
    logic [31:0] r_l26_d;
    logic        r_v_d;
    logic [63:0] w_lprod;

    assign w_lprod = {28'b0, r_n} * {36'b0, LN2_Q28} + (64'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n     <= {r_e[LOG_ITERS], 30'b0} - {{(36 - LOG_ITERS){1'b0}}, r_fr[LOG_ITERS]};
            r_l26   <= w_lprod[63:32];
            r_l26_d <= r_l26;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_n <= 1'b0;
            r_v_l <= 1'b0;
            r_v_d <= 1'b0;
        end else if (i_en) begin
            r_v_n <= r_v[LOG_ITERS];
            r_v_l <= r_v_n;
            r_v_d <= r_v_l;
        end
    end

    assign o_valid = r_v_d;
    assign o_l26   = r_l26_d;

endmodule

>>> sv/pgt_div.sv
// two-lane restoring divider for v^2/s, one quotient bit per stage
module pgt_div import pgt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [T_W-1:0] i_pa,
    input  logic [T_W-1:0] i_pb,
    input  logic [D_W-1:0] i_d,
    input  logic           i_na,
    input  logic           i_nb,
    output logic [Q_W-1:0] o_ra,
    output logic [Q_W-1:0] o_rb,
    output logic           o_na,
    output logic           o_nb
);

    logic [63:0]    r_xa [1:Q_W];
    logic [63:0]    r_xb [1:Q_W];
    logic [Q_W-1:0] r_qa [1:Q_W];
    logic [Q_W-1:0] r_qb [1:Q_W];
    logic [D_W-1:0] r_d  [1:Q_W];
    logic           r_na [1:Q_W];
    logic           r_nb [1:Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_bit
        localparam int K = Q_W - 1 - j;
        logic [63:0]    w_xa, w_xb, w_dsh;
        logic [Q_W-1:0] w_qa, w_qb;
        logic [D_W-1:0] w_d;
        logic           w_na, w_nb;
        logic [63:0]    n_xa, n_xb;
        logic [Q_W-1:0] n_qa, n_qb;

        if (j == 0) begin : g_first
            assign w_xa = {i_pa, 3'b0};
            assign w_xb = {i_pb, 3'b0};
            assign w_qa = '0;
            assign w_qb = '0;
            assign w_d  = i_d;
            assign w_na = i_na;
            assign w_nb = i_nb;
        end else begin : g_next
            assign w_xa = r_xa[j];
            assign w_xb = r_xb[j];
            assign w_qa = r_qa[j];
            assign w_qb = r_qb[j];
            assign w_d  = r_d[j];
            assign w_na = r_na[j];
            assign w_nb = r_nb[j];
        end

        assign w_dsh = {{(64 - D_W){1'b0}}, w_d} << K;

        always_comb begin
            n_xa = w_xa;
            n_qa = w_qa;
            if (w_xa >= w_dsh) begin
                n_xa    = w_xa - w_dsh;
                n_qa[K] = 1'b1;
            end
            n_xb = w_xb;
            n_qb = w_qb;
            if (w_xb >= w_dsh) begin
                n_xb    = w_xb - w_dsh;
                n_qb[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xa[j+1] <= n_xa;
                r_xb[j+1] <= n_xb;
                r_qa[j+1] <= n_qa;
                r_qb[j+1] <= n_qb;
                r_d[j+1]  <= w_d;
                r_na[j+1] <= w_na;
                r_nb[j+1] <= w_nb;
            end
        end
    end

    localparam logic [Q_W-1:0] R_MAX = Q_W'(64'd1 << 31);

    logic [Q_W-1:0] r_ra, r_rb;
    logic           r_na_o, r_nb_o;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ra   <= (r_qa[Q_W] > R_MAX) ? R_MAX : r_qa[Q_W];
            r_rb   <= (r_qb[Q_W] > R_MAX) ? R_MAX : r_qb[Q_W];
            r_na_o <= r_na[Q_W];
            r_nb_o <= r_nb[Q_W];
        end
    end

    assign o_ra = r_ra;
    assign o_rb = r_rb;
    assign o_na = r_na_o;
    assign o_nb = r_nb_o;

endmodule

>>> sv/pgt_sqrt.sv
// two-lane digit-by-digit integer square root, one root bit per stage
module pgt_sqrt import pgt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [63:0]          i_xa,
    input  logic [63:0]          i_xb,
    input  logic                 i_na,
    input  logic                 i_nb,
    output logic                 o_valid,
    output logic [SQRT_BITS-1:0] o_ma,
    output logic [SQRT_BITS-1:0] o_mb,
    output logic                 o_na,
    output logic                 o_nb
);

    logic [63:0]          r_ra [1:SQRT_BITS];
    logic [63:0]          r_rb [1:SQRT_BITS];
    logic [SQRT_BITS-1:0] r_sa [1:SQRT_BITS];
    logic [SQRT_BITS-1:0] r_sb [1:SQRT_BITS];
    logic                 r_na [1:SQRT_BITS];
    logic                 r_nb [1:SQRT_BITS];
    logic                 r_v  [1:SQRT_BITS];

    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_bit
        localparam int B = SQRT_BITS - 1 - j;
        logic [63:0]          w_ra, w_rb, w_inca, w_incb;
        logic [SQRT_BITS-1:0] w_sa, w_sb;
        logic                 w_na, w_nb, w_v;
        logic [63:0]          n_ra, n_rb;
        logic [SQRT_BITS-1:0] n_sa, n_sb;

        if (j == 0) begin : g_first
            assign w_ra = i_xa;
            assign w_rb = i_xb;
            assign w_sa = '0;
            assign w_sb = '0;
            assign w_na = i_na;
            assign w_nb = i_nb;
            assign w_v  = i_valid;
        end else begin : g_next
            assign w_ra = r_ra[j];
            assign w_rb = r_rb[j];
            assign w_sa = r_sa[j];
            assign w_sb = r_sb[j];
            assign w_na = r_na[j];
            assign w_nb = r_nb[j];
            assign w_v  = r_v[j];
        end

        assign w_inca = ({{(64 - SQRT_BITS){1'b0}}, w_sa} << (B + 1)) + (64'd1 << (2 * B));
        assign w_incb = ({{(64 - SQRT_BITS){1'b0}}, w_sb} << (B + 1)) + (64'd1 << (2 * B));

        always_comb begin
            n_ra = w_ra;
            n_sa = w_sa;
            if (w_ra >= w_inca) begin
                n_ra    = w_ra - w_inca;
                n_sa[B] = 1'b1;
            end
            n_rb = w_rb;
            n_sb = w_sb;
            if (w_rb >= w_incb) begin
                n_rb    = w_rb - w_incb;
                n_sb[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ra[j+1] <= n_ra;
                r_rb[j+1] <= n_rb;
                r_sa[j+1] <= n_sa;
                r_sb[j+1] <= n_sb;
                r_na[j+1] <= w_na;
                r_nb[j+1] <= w_nb;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= w_v;
            end
        end
    end

    assign o_valid = r_v[SQRT_BITS];
    assign o_ma    = r_sa[SQRT_BITS];
    assign o_mb    = r_sb[SQRT_BITS];
    assign o_na    = r_na[SQRT_BITS];
    assign o_nb    = r_nb[SQRT_BITS];

endmodule

>>> sv/polar_gaussian_transform_unit.sv
// top level of the polar gaussian transform unit
//
//  channel  | dir | tdata                                   | tlast
//  s_axis   | in  | [31:0] uniform_a, [63:32] uniform_b     | -
//  m_axis   | out | [31:0] normal_value                     | last
//
// while words flow, a new uniform pair is taken only once both words of the last pair have
// gone out: the output register sends two words per pair and the whole pipeline advances only
// when that register can reload; with the output register empty a pair is taken in every cycle.
// the first word leaves after the pair has passed the front, normalize, log and divide,
// multiply, square root and output registers.
// rejected pairs leave a bubble and give no word.
// reset clears valid bits and the busy and phase flags; a stall on m_axis freezes all stages.
`include "polar_gaussian_transform_unit_defines.svh"

module polar_gaussian_transform_unit import pgt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // uniform_a, uniform_b
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // normal_value
    output logic        o_m_axis_tlast
);

    logic w_en;

    logic        r_busy, r_phase;
    logic [31:0] r_word0, r_word1;

    assign w_en            = !r_busy || (i_m_axis_tready && r_phase);
    assign o_s_axis_tready = w_en;

    // front end
    logic [30:0] w_ua, w_ub, w_aa, w_ab;
    logic [30:0] r_aa, r_ab;
    logic        r_na_a, r_nb_a, r_v_a;
    logic [61:0] w_sqa, w_sqb;
    logic [T_W-1:0] r_sqa, r_sqb;
    logic        r_na_b, r_nb_b, r_v_b;
    logic [61:0] w_s;
    t_norm_data  r_c;
    logic        r_v_c;

    assign w_ua  = to_q31(i_s_axis_tdata[31:0]);
    assign w_ub  = to_q31(i_s_axis_tdata[63:32]);
    assign w_aa  = w_ua[30] ? (w_ua - (31'd1 << 30)) : ((31'd1 << 30) - w_ua);
    assign w_ab  = w_ub[30] ? (w_ub - (31'd1 << 30)) : ((31'd1 << 30) - w_ub);
    assign w_sqa = {31'b0, r_aa} * {31'b0, r_aa};
    assign w_sqb = {31'b0, r_ab} * {31'b0, r_ab};
    assign w_s   = {1'b0, r_sqa} + {1'b0, r_sqb};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aa    <= w_aa;
            r_ab    <= w_ab;
            r_na_a  <= !w_ua[30];
            r_nb_a  <= !w_ub[30];
            r_sqa   <= w_sqa[T_W-1:0];
            r_sqb   <= w_sqb[T_W-1:0];
            r_na_b  <= r_na_a;
            r_nb_b  <= r_nb_a;
            r_c.t   <= w_s[T_W-1:0];
            r_c.pa  <= r_sqa;
            r_c.pb  <= r_sqb;
            r_c.e   <= '0;
            r_c.na  <= r_na_b;
            r_c.nb  <= r_nb_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
        end else if (w_en) begin
            r_v_a <= i_s_axis_tvalid;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b && (w_s != '0) && (w_s[61:60] == 2'b00);
        end
    end

    // normalize
    logic       w_norm_v;
    t_norm_data w_norm;

    pgt_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v_c),
        .i_data  (r_c),
        .o_valid (w_norm_v),
        .o_data  (w_norm)
    );

    // log and ratio side by side
    logic           w_log_v;
    logic [31:0]    w_l26;
    logic [Q_W-1:0] w_ra, w_rb;
    logic           w_dna, w_dnb;

    pgt_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_norm_v),
        .i_t     (w_norm.t),
        .i_e     (w_norm.e),
        .o_valid (w_log_v),
        .o_l26   (w_l26)
    );

    pgt_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_pa  (w_norm.pa),
        .i_pb  (w_norm.pb),
        .i_d   (w_norm.t[T_W-1:28]),
        .i_na  (w_norm.na),
        .i_nb  (w_norm.nb),
        .o_ra  (w_ra),
        .o_rb  (w_rb),
        .o_na  (w_dna),
        .o_nb  (w_dnb)
    );

    // squared deviates
    logic [63:0] r_xa, r_xb;
    logic        r_na_m, r_nb_m, r_v_m;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xa   <= {32'b0, w_l26} * {{(64 - Q_W){1'b0}}, w_ra};
            r_xb   <= {32'b0, w_l26} * {{(64 - Q_W){1'b0}}, w_rb};
            r_na_m <= w_dna;
            r_nb_m <= w_dnb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_m <= 1'b0;
        end else if (w_en) begin
            r_v_m <= w_log_v;
        end
    end

    // square root
    logic                 w_sq_v, w_sna, w_snb;
    logic [SQRT_BITS-1:0] w_ma, w_mb;

    pgt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v_m),
        .i_xa    (r_xa),
        .i_xb    (r_xb),
        .i_na    (r_na_m),
        .i_nb    (r_nb_m),
        .o_valid (w_sq_v),
        .o_ma    (w_ma),
        .o_mb    (w_mb),
        .o_na    (w_sna),
        .o_nb    (w_snb)
    );

    // scaling, sign and saturation
    function automatic logic [31:0] finish(input logic [SQRT_BITS-1:0] mag, input logic neg);
        logic [63:0] m;
        logic [63:0] v;
        m = {{(64 - SQRT_BITS){1'b0}}, mag};
        if (OUT_FRAC_BITS >= 28) begin
            m = m << O_SHL;
        end else begin
            m = (m + (64'd1 << (O_SHR - 1))) >> O_SHR;
        end
        if (neg) begin
            if (m > (64'd1 << 31)) begin
                m = 64'd1 << 31;
            end
            v = 64'd0 - m;
        end else begin
            v = (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_word0 <= finish(w_ma, w_sna);
            r_word1 <= finish(w_mb, w_snb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (w_en) begin
            r_busy  <= w_sq_v;
            r_phase <= 1'b0;
        end else if (r_busy && !r_phase && i_m_axis_tready) begin
            r_phase <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tdata  = r_phase ? r_word1 : r_word0;
    assign o_m_axis_tlast  = r_phase;

    `PGT_ASSERT_NEXT(a_second_word_follows, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast,
        o_m_axis_tvalid && o_m_axis_tlast)
    `PGT_ASSERT_SAME(a_hold_input_mid_pair, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready)

endmodule

>>> tb/sv/tb.sv
// testbench for the polar gaussian transform unit
`timescale 1ns / 100ps

module tb;
    import pgt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // uniform_a, uniform_b
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // normal_value
    logic        o_m_axis_tlast;

    typedef struct packed {
        logic [31:0] normal_value;
        logic        last;
    } t_deviate;

    t_deviate    deviate_q[$];
    int          mismatch_cnt;
    int          pairs_sent;
    int          pairs_rejected;
    int          words_checked;

    polar_gaussian_transform_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] unit_q31(input logic [31:0] raw);
        logic [63:0] u;
        u = {32'd0, raw} & ((64'd1 << UNIFORM_BITS) - 64'd1);
        if (UNIFORM_BITS >= 31) return u >> (UNIFORM_BITS - 31);
        return u << (31 - UNIFORM_BITS);
    endfunction

    function automatic logic [31:0] scaled_deviate(input logic [63:0] mag_v, input bit neg,
                                                   input int e, input logic [63:0] t,
                                                   input logic [63:0] l26);
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] mag;
        p = (mag_v * mag_v) << e;
        r = (p << 3) / (t >> 28);
        if (r > (64'd1 << 31)) r = 64'd1 << 31;
        mag = int_sqrt(l26 * r);
        if (OUT_FRAC_BITS >= 28) mag = mag << (OUT_FRAC_BITS - 28);
        else mag = (mag + (64'd1 << (27 - OUT_FRAC_BITS))) >> (28 - OUT_FRAC_BITS);
        if (neg) begin
            if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // pushes the two deviates of an accepted pair, nothing if the pair is rejected
    task automatic predict_deviates(input logic [31:0] ua_raw, input logic [31:0] ub_raw);
        logic [63:0] ua, ub, aa, ab, s, t, f, fr, n, l26;
        logic [63:0] half;
        bit          na, nb;
        int          e;
        t_deviate    w;
        half = 64'd1 << 30;
        ua = unit_q31(ua_raw);
        ub = unit_q31(ub_raw);
        na = ua < half;
        nb = ub < half;
        aa = na ? half - ua : ua - half;
        ab = nb ? half - ub : ub - half;
        s  = aa * aa + ab * ab;
        if (s == 0 || s >= (64'd1 << 60)) begin
            pairs_rejected++;
            return;
        end
        t = s;
        e = 0;
        while (t < (64'd1 << 60)) begin
            t = t << 1;
            e++;
        end
        f  = t >> 30;
        fr = 64'd0;
        for (int i = 0; i < 30; i++) begin
            f  = (f * f) >> 30;
            fr = fr << 1;
            if (f >= (64'd1 << 31)) begin
                f  = f >> 1;
                fr = fr | 64'd1;
            end
        end
        n   = (64'(e) << 30) - fr;
        l26 = (n * 64'(LN2_Q28) + (64'd1 << 31)) >> 32;
        w.normal_value = scaled_deviate(aa, na, e, t, l26);
        w.last = 1'b0;
        deviate_q.push_back(w);
        w.normal_value = scaled_deviate(ab, nb, e, t, l26);
        w.last = 1'b1;
        deviate_q.push_back(w);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_pair(input logic [31:0] ua, input logic [31:0] ub, input bit bursty);
        int gap;
        gap = bursty ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = {$urandom, $urandom};
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {ub, ua};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_deviates(ua, ub);
        pairs_sent++;
    endtask

    // receiver stall pattern
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                i_m_axis_tready = (gap == 0);
                repeat (gap) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_deviate exp_w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            words_checked++;
            if (deviate_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected word: value %h last %b", o_m_axis_tdata,
                             o_m_axis_tlast);
            end else begin
                exp_w = deviate_q.pop_front();
                if (exp_w.normal_value !== o_m_axis_tdata || exp_w.last !== o_m_axis_tlast) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("word mismatch: expected %h/%b actual %h/%b",
                                 exp_w.normal_value, exp_w.last, o_m_axis_tdata,
                                 o_m_axis_tlast);
                end
            end
        end
    end

    task automatic test_directed();
        send_pair(32'h0000_0000, 32'h0000_0000, 0);   // corner, s = 2, rejected
        send_pair(32'h8000_0000, 32'h8000_0000, 0);   // s = 0, rejected
        send_pair(32'h8000_0001, 32'h8000_0000, 0);   // truncated lsb, s = 0
        send_pair(32'h0000_0000, 32'h8000_0000, 0);   // s exactly one, rejected
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);   // near corner, rejected
        send_pair(32'h8000_0002, 32'h8000_0000, 0);   // smallest s, second zero
        send_pair(32'h8000_0000, 32'h7FFF_FFFE, 0);   // zero first, tiny negative
        send_pair(32'h0000_0002, 32'h8000_0000, 0);   // just inside on the left
        send_pair(32'hFFFF_FFFE, 32'h8000_0000, 0);   // just inside on the right
        send_pair(32'h8000_0000, 32'h0000_0002, 0);
        send_pair(32'h8000_0000, 32'hFFFF_FFFE, 0);
        send_pair(32'hC000_0000, 32'h4000_0000, 0);
        send_pair(32'h4000_0000, 32'hC000_0000, 0);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_pair(32'h8000_0400, 32'h7FFF_FC00, 0);
        send_pair(32'h2D41_3CCC, 32'h2D41_3CCC, 0);   // close to the unit circle
        send_pair(32'hD2BE_C334, 32'hD2BE_C334, 0);
    endtask

    task automatic test_random_pairs(input int count);
        for (int i = 0; i < count; i++)
            send_pair($urandom, $urandom, (i % 200) < 40);
    endtask

    // small s, where the log and the divide see their largest shifts
    task automatic test_near_center(input int count);
        logic [31:0] da, db;
        int          w;
        for (int i = 0; i < count; i++) begin
            w  = $urandom_range(1, 30);
            da = $urandom & ((32'd1 << w) - 1);
            db = $urandom & ((32'd1 << w) - 1);
            send_pair($urandom_range(0, 1) ? 32'h8000_0000 + da : 32'h8000_0000 - da,
                      $urandom_range(0, 1) ? 32'h8000_0000 + db : 32'h8000_0000 - db, 0);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 64'd0;
        mismatch_cnt    = 0;
        pairs_sent      = 0;
        pairs_rejected  = 0;
        words_checked   = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_pairs(1000);
        test_near_center(330);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (deviate_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("pairs sent %0d, rejected %0d, deviates checked %0d",
                 pairs_sent, pairs_rejected, words_checked);
        $display("covered corners, zero coordinates, rejection cases and small radii");
        if (mismatch_cnt == 0 && deviate_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule
